/* src/rpn_pkg.sv */
`timescale 1ns / 1ps

package rpn_pkg;

  // Field widths
  localparam int VAL_W  = 48;
  localparam int ACT_W  = 3;
  localparam int DIG_W  = 4;
  localparam int STAT_W = 3;

  // Token actions
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_END     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_INVALID = 3'd6;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd5;

  localparam logic [DIG_W-1:0] MAX_DIGIT = 4'd9;

  // Saturation bounds of the signed value
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic signed [VAL_W-1:0] val_t;

  // Request from the sequencer to the multiply/divide unit
  typedef struct packed {
    logic start;
    logic div;
  } alu_ctl_t;

endpackage

/* src/rpn_tok_if.sv */
`timescale 1ns / 1ps

interface rpn_tok_if import rpn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [DIG_W-1:0] digit;

  modport source (output valid, action, digit, input ready);
  modport sink   (input valid, action, digit, output ready);
endinterface

/* src/rpn_res_if.sv */
`timescale 1ns / 1ps

interface rpn_res_if import rpn_pkg::*; ();
  logic              valid;
  logic              ready;
  val_t              value;
  logic [STAT_W-1:0] status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

/* src/rpn_alu.sv */
`timescale 1ns / 1ps

module rpn_alu import rpn_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  alu_ctl_t ctl,
  input  val_t     a,
  input  val_t     b,
  output logic     done,
  output val_t     result
);

  localparam int PW = 2 * VAL_W;           // full product width
  localparam int NW = VAL_W + FRAC_BITS;   // scaled dividend / quotient width
  localparam int CW = $clog2(NW);
  localparam logic [CW-1:0] MUL_LAST = CW'(VAL_W - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;
  localparam logic [1:0] A_FIN  = 2'd3;

  logic [1:0]       state;
  logic [CW-1:0]    cnt;
  logic             neg;
  logic             last_div;
  logic [VAL_W-1:0] mag_a;
  logic [VAL_W-1:0] mag_b;
  logic [PW-1:0]    prod;
  logic [NW-1:0]    num;
  logic [VAL_W-1:0] rem;

  logic [VAL_W-1:0] in_mag_a;
  logic [VAL_W-1:0] in_mag_b;
  logic [VAL_W:0]   mul_sum;
  logic [VAL_W:0]   div_rs;
  logic [VAL_W:0]   div_diff;
  logic             div_ge;
  logic [PW-1:0]    wmag;
  logic             big;

  // Operand magnitudes; the most negative value maps to 2^47
  assign in_mag_a = a[VAL_W-1] ? (~a + 1'b1) : a;
  assign in_mag_b = b[VAL_W-1] ? (~b + 1'b1) : b;

  // Shift-add multiply step: add multiplicand into the upper half, shift right
  assign mul_sum = {1'b0, prod[PW-1:VAL_W]} + (prod[0] ? {1'b0, mag_a} : '0);

  // Restoring divide step: bring in one dividend bit, subtract if it fits
  assign div_rs   = {rem, num[NW-1]};
  assign div_diff = div_rs - {1'b0, mag_b};
  assign div_ge   = div_rs >= {1'b0, mag_b};

  // Scale, then saturate the signed result
  assign wmag = last_div ? PW'(num) : (prod >> FRAC_BITS);
  assign big  = |wmag[PW-1:VAL_W-1];
  assign done = (state == A_FIN);

  always_comb begin
    if (neg) begin
      result = big ? VAL_MIN : val_t'(~wmag[VAL_W-1:0] + 1'b1);
    end else begin
      result = big ? VAL_MAX : val_t'(wmag[VAL_W-1:0]);
    end
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: if (ctl.start) begin
          state <= ctl.div ? A_DIV : A_MUL;
        end
        A_MUL: if (cnt == MUL_LAST) begin
          state <= A_FIN;
        end
        A_DIV: if (cnt == DIV_LAST) begin
          state <= A_FIN;
        end
        A_FIN: state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

  // Remember which operation finished
  always_ff @(posedge clk) begin
    if (state == A_IDLE && ctl.start) begin
      last_div <= ctl.div;
    end
  end

  // Load operands and run the datapath
  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        cnt   <= '0;
        neg   <= a[VAL_W-1] ^ b[VAL_W-1];
        mag_a <= in_mag_a;
        mag_b <= in_mag_b;
        prod  <= {{VAL_W{1'b0}}, in_mag_b};
        num   <= NW'(in_mag_a) << FRAC_BITS;
        rem   <= '0;
      end
      A_MUL: begin
        cnt  <= cnt + 1'b1;
        prod <= {mul_sum, prod[VAL_W-1:1]};
      end
      A_DIV: begin
        cnt <= cnt + 1'b1;
        rem <= div_ge ? div_diff[VAL_W-1:0] : div_rs[VAL_W-1:0];
        num <= {num[NW-2:0], div_ge};
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

/* src/rpn_stack_evaluator.sv */
`timescale 1ns / 1ps

// RPN expression evaluator, one token per request on the tok channel.
// A push token places its digit on the operand stack, an operator pops two
// operands and pushes the result, an end token sends one request on the res
// channel carrying the top of stack (or zero) and a status, then empties the
// stack and clears any error. No other token produces a result.
// The result request is registered: it is loaded when its end token is
// taken, or, if a result is still pending, once that result is taken.
// Push, end and invalid tokens are handled as they are taken; add and
// subtract also wait for the registered read of the left operand from the
// stack memory; multiply and divide wait for the one-bit-per-cycle unit.
// The top of stack sits in a register; the entries below it live in a
// single-port-write, registered-read memory of STACK_DEPTH entries.
// Reset empties the stack and clears the error; no clearing pass is needed.
// The tok channel is not ready while reset is high.
// Results sit in an output register, so tokens keep flowing while a result
// waits; only a second end token waits until the pending result is taken.
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst,
  rpn_tok_if.sink   tok,
  rpn_res_if.source res
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_ALU   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]        state;
  logic [SPW-1:0]    sp;
  logic [STAT_W-1:0] err;
  logic [ACT_W-1:0]  op;
  val_t              tos;
  val_t              mem [STACK_DEPTH];
  val_t              mem_rd;
  logic              out_valid;
  val_t              out_value;
  logic [STAT_W-1:0] out_status;

  logic              tok_acc;
  logic              is_end;
  logic              slot_free;
  logic              emit_go;
  logic              push_go;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [SPW-1:0]    sp_m1;
  logic [SPW-1:0]    sp_m2;
  logic [VAL_W:0]    as_sum;
  val_t              as_res;
  logic [STAT_W-1:0] emit_status;
  alu_ctl_t          alu_ctl;
  logic              alu_done;
  val_t              alu_result;

  assign tok.ready  = (state == S_IDLE) && !rst;
  assign tok_acc    = tok.valid && tok.ready;
  assign is_end     = (tok.action == ACT_END);
  assign slot_free  = !out_valid || res.ready;
  assign emit_go    = slot_free && ((tok_acc && is_end) || state == S_EMIT);
  assign push_go    = tok_acc && err == ST_OK && tok.action == ACT_PUSH &&
                      tok.digit <= MAX_DIGIT && sp < SPW'(STACK_DEPTH);

  assign res.valid  = out_valid;
  assign res.value  = out_value;
  assign res.status = out_status;

  // Stack addressing: entry below the top is written on push, read for operators
  assign sp_m1   = sp - 1'b1;
  assign sp_m2   = sp - SPW'(2);
  assign wr_addr = sp_m1[AW-1:0];
  assign rd_addr = sp_m2[AW-1:0];

  // Saturating add/subtract of left (memory) and right (top of stack)
  assign as_sum = (op == ACT_SUB) ? {mem_rd[VAL_W-1], mem_rd} - {tos[VAL_W-1], tos}
                                  : {mem_rd[VAL_W-1], mem_rd} + {tos[VAL_W-1], tos};
  always_comb begin
    if (as_sum[VAL_W] != as_sum[VAL_W-1]) begin
      as_res = as_sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      as_res = val_t'(as_sum[VAL_W-1:0]);
    end
  end

  // Status for an end token
  always_comb begin
    if (err != ST_OK) begin
      emit_status = err;
    end else if (sp == '0) begin
      emit_status = ST_EMPTY;
    end else begin
      emit_status = ST_OK;
    end
  end

  assign alu_ctl.start = (state == S_FETCH) && (op == ACT_MUL || op == ACT_DIV);
  assign alu_ctl.div   = (op == ACT_DIV);

  rpn_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .a      (mem_rd),
    .b      (tos),
    .done   (alu_done),
    .result (alu_result)
  );

  // Stack memory: one write on push, registered read every cycle.
  // A push and a later operator never touch the memory at the same edge.
  always_ff @(posedge clk) begin
    if (push_go && sp != '0) begin
      mem[wr_addr] <= tos;
    end
    mem_rd <= mem[rd_addr];
  end

  // Control: state, stack pointer, sticky error, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
        sp        <= '0;
        err       <= ST_OK;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tok_acc && is_end) begin
            if (!slot_free) begin
              state <= S_EMIT;
            end
          end else if (tok_acc && err == ST_OK) begin
            case (tok.action)
              ACT_PUSH: begin
                if (tok.digit > MAX_DIGIT) begin
                  err <= ST_INVALID;
                end else if (sp >= SPW'(STACK_DEPTH)) begin
                  err <= ST_OVERFLOW;
                end else begin
                  sp <= sp + 1'b1;
                end
              end
              ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                if (sp < SPW'(2)) begin
                  err <= ST_UNDERFLOW;
                end else if (tok.action == ACT_DIV && tos == '0) begin
                  err <= ST_DIVZERO;
                end else begin
                  state <= S_FETCH;
                end
              end
              default: err <= ST_INVALID;
            endcase
          end
        end
        S_FETCH: begin
          if (op == ACT_ADD || op == ACT_SUB) begin
            sp    <= sp_m1;
            state <= S_IDLE;
          end else begin
            state <= S_ALU;
          end
        end
        S_ALU: if (alu_done) begin
          sp    <= sp_m1;
          state <= S_IDLE;
        end
        S_EMIT: if (slot_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: top of stack, latched operator, output payload
  always_ff @(posedge clk) begin
    if (tok_acc) begin
      op <= tok.action;
    end
    if (push_go) begin
      tos <= val_t'(VAL_W'(tok.digit) << FRAC_BITS);
    end else if (state == S_FETCH && (op == ACT_ADD || op == ACT_SUB)) begin
      tos <= as_res;
    end else if (state == S_ALU && alu_done) begin
      tos <= alu_result;
    end
    if (emit_go) begin
      out_status <= emit_status;
      out_value  <= (emit_status == ST_OK) ? tos : '0;
    end
  end

endmodule
